### design/pph_pkg.sv
// Package for the planar PID heading tracker.
// Holds widths, register indexes and the CORDIC arctangent table.
// No dependencies.
package pph_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int ANG_FRAC     = 22;
    localparam int RUN_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W       = $clog2(TABLE_LEN + 1);
    localparam int ANG_W        = 32;
    localparam int MUL_CNT_W    = 6;

    typedef enum logic [2:0] {
        REG_GAIN_PREVIEW    = 3'd0,
        REG_GAIN_TARGET     = 3'd1,
        REG_GAIN_INTEGRAL   = 3'd2,
        REG_GAIN_DERIVATIVE = 3'd3,
        REG_INTEGRAL_LIMIT  = 3'd4,
        REG_START_HEADING   = 3'd5
    } reg_index_t;

    function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
        logic signed [ANG_W-1:0] r;
        begin
            case (i)
                0:  r = 32'sd188743680;
                1:  r = 32'sd111421900;
                2:  r = 32'sd58872272;
                3:  r = 32'sd29884485;
                4:  r = 32'sd15000234;
                5:  r = 32'sd7507429;
                6:  r = 32'sd3754631;
                7:  r = 32'sd1877430;
                8:  r = 32'sd938729;
                9:  r = 32'sd469366;
                10: r = 32'sd234683;
                11: r = 32'sd117342;
                12: r = 32'sd58671;
                13: r = 32'sd29335;
                14: r = 32'sd14668;
                15: r = 32'sd7334;
                16: r = 32'sd3667;
                17: r = 32'sd1833;
                18: r = 32'sd917;
                19: r = 32'sd458;
                20: r = 32'sd229;
                21: r = 32'sd115;
                22: r = 32'sd57;
                23: r = 32'sd29;
                default: r = '0;
            endcase
            return r;
        end
    endfunction

endpackage

### design/pph_mul.sv
// Bit-serial signed 32x33 multiplier, one multiplier bit per cycle.
// Result is the floored product shifted right by FRAC_BITS. Uses pph_pkg.
module pph_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [31:0] a,
    input  logic signed [32:0] b,
    output logic               done,
    output logic signed [64:0] product
);
    import pph_pkg::*;

    logic [MUL_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic signed [65:0]   acc_reg, acc_next;
    logic [32:0]          b_reg, b_next;
    logic signed [65:0]   a_ext;
    logic signed [65:0]   addend;

    assign a_ext = {{34{a[31]}}, a} <<< cnt_reg;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        b_next    = b_reg;
        addend    = b_reg[0] ? a_ext : '0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            acc_next  = '0;
            b_next    = b;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == MUL_CNT_W'(32))
                acc_next = acc_reg - addend;
            else
                acc_next = acc_reg + addend;
            b_next = {1'b0, b_reg[32:1]};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == MUL_CNT_W'(32))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        b_reg   <= b_next;
    end

    assign done    = busy_reg && (cnt_reg == MUL_CNT_W'(32));
    assign product = 65'(acc_next >>> FRAC_BITS);
endmodule

### design/planar_pid_heading_tracker.sv
// Top level of the planar PID heading tracker.
// Depends on pph_pkg and pph_mul.
//
// One beat in, one beat out. An item runs eight gain products, all done one
// bit per cycle on a single shared serial multiplier, then the CORDIC atan2
// steps and the control states. in_stall is high from acceptance until the
// result has been moved into the output register.
module planar_pid_heading_tracker (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [2:0]                cfg_index,
    input  logic [31:0]               cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic signed [31:0]        preview_x,
    input  logic signed [31:0]        preview_y,
    input  logic signed [31:0]        goal_x,
    input  logic signed [31:0]        goal_y,
    input  logic signed [31:0]        current_x,
    input  logic signed [31:0]        current_y,
    input  logic                      use_start_heading,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic signed [8:0]         heading_deg,
    output logic signed [31:0]        drive_x,
    output logic signed [31:0]        drive_y
);
    import pph_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_ERR   = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_WAIT  = 6'b001000,
        ST_CORD  = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] gp_reg, gt_reg, gi_reg, gd_reg;
    logic [30:0]        lim_reg;
    logic signed [8:0]  sh_reg;

    logic signed [31:0] ix_reg, iy_reg, px_reg, py_reg;

    logic signed [31:0] ex_reg, ey_reg, tx_reg, ty_reg;
    logic signed [32:0] dx_reg, dy_reg;
    logic               use_reg;
    logic [2:0]         term_reg;
    logic signed [67:0] sx_reg, sy_reg;

    logic signed [33:0] cx_reg, cy_reg;
    logic signed [ANG_W-1:0] z_reg;
    logic [STEP_W-1:0]  step_reg;

    logic               ov_reg;
    logic signed [8:0]  oh_reg;
    logic signed [31:0] odx_reg, ody_reg;

    logic               mul_start;
    logic               mul_done;
    logic signed [31:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [64:0] mul_p;

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        begin
            if (v > 68'sh7FFFFFFF)
                return 32'sh7FFFFFFF;
            else if (v < -68'sh80000000)
                return 32'sh80000000;
            else
                return v[31:0];
        end
    endfunction

    function automatic logic signed [31:0] clamp_int(input logic signed [32:0] v,
                                                     input logic [30:0] l);
        logic signed [32:0] hi;
        begin
            hi = {2'b00, l};
            if (v > hi)
                return hi[31:0];
            else if (v < -hi)
                return 32'(-hi);
            else
                return v[31:0];
        end
    endfunction

    assign cfg_ready = (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gp_reg  <= '0;
            gt_reg  <= '0;
            gi_reg  <= '0;
            gd_reg  <= '0;
            lim_reg <= 31'd6553600;
            sh_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_GAIN_PREVIEW:    gp_reg  <= cfg_data;
                REG_GAIN_TARGET:     gt_reg  <= cfg_data;
                REG_GAIN_INTEGRAL:   gi_reg  <= cfg_data;
                REG_GAIN_DERIVATIVE: gd_reg  <= cfg_data;
                REG_INTEGRAL_LIMIT:  lim_reg <= cfg_data[30:0];
                REG_START_HEADING:   sh_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    // term order: 0 ex,1 tx,2 ix,3 dx,4 ey,5 ty,6 iy,7 dy
    always_comb
    begin
        case (term_reg[1:0])
            2'd0: mul_a = gp_reg;
            2'd1: mul_a = gt_reg;
            2'd2: mul_a = gi_reg;
            default: mul_a = gd_reg;
        endcase
        case (term_reg)
            3'd0: mul_b = 33'(ex_reg);
            3'd1: mul_b = 33'(tx_reg);
            3'd2: mul_b = 33'(ix_reg);
            3'd3: mul_b = dx_reg;
            3'd4: mul_b = 33'(ey_reg);
            3'd5: mul_b = 33'(ty_reg);
            3'd6: mul_b = 33'(iy_reg);
            default: mul_b = dy_reg;
        endcase
    end

    assign mul_start = (state_reg == ST_MUL);

    pph_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .product (mul_p)
    );

    logic signed [31:0] drv_x, drv_y;
    logic signed [31:0] fin_y;
    logic signed [33:0] shx, shy;

    assign drv_x = sat32(sx_reg);
    assign drv_y = sat32(sy_reg);
    assign fin_y = sat32(sy_reg + 68'(mul_p));
    assign shx   = cx_reg >>> step_reg;
    assign shy   = cy_reg >>> step_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_ERR;
            ST_ERR:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_WAIT;
            ST_WAIT:
                if (mul_done)
                    state_next = (term_reg == 3'd7) ? ST_CORD : ST_MUL;
            ST_CORD:
                if (step_reg == STEP_W'(RUN_STEPS)) state_next = ST_DONE;
            ST_DONE: if (!ov_reg || !out_stall) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
            ix_reg    <= '0;
            iy_reg    <= '0;
            px_reg    <= '0;
            py_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DONE && (!ov_reg || !out_stall))
                ov_reg <= 1'b1;
            else if (ov_reg && !out_stall)
                ov_reg <= 1'b0;
            if (state_reg == ST_ERR)
            begin
                ix_reg <= clamp_int(33'(ix_reg) + 33'(tx_reg), lim_reg);
                iy_reg <= clamp_int(33'(iy_reg) + 33'(ty_reg), lim_reg);
                px_reg <= tx_reg;
                py_reg <= ty_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_valid)
        begin
            ex_reg   <= sat32(68'(preview_x) - 68'(current_x));
            ey_reg   <= sat32(68'(preview_y) - 68'(current_y));
            tx_reg   <= sat32(68'(goal_x) - 68'(current_x));
            ty_reg   <= sat32(68'(goal_y) - 68'(current_y));
            use_reg  <= use_start_heading;
            term_reg <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
        end
        if (state_reg == ST_ERR)
        begin
            dx_reg <= 33'(tx_reg) - 33'(px_reg);
            dy_reg <= 33'(ty_reg) - 33'(py_reg);
        end
        if (state_reg == ST_WAIT && mul_done)
        begin
            if (term_reg[2])
                sy_reg <= sy_reg + 68'(mul_p);
            else
                sx_reg <= sx_reg + 68'(mul_p);
            term_reg <= term_reg + 1'b1;
            if (term_reg == 3'd7)
            begin
                step_reg <= '0;
                if (drv_x < 0 && fin_y >= 0)
                begin
                    cx_reg <= 34'(fin_y);
                    cy_reg <= -34'(drv_x);
                    z_reg  <= ANG_W'(90) <<< ANG_FRAC;
                end
                else if (drv_x < 0)
                begin
                    cx_reg <= -34'(fin_y);
                    cy_reg <= 34'(drv_x);
                    z_reg  <= -(ANG_W'(90) <<< ANG_FRAC);
                end
                else
                begin
                    cx_reg <= 34'(drv_x);
                    cy_reg <= 34'(fin_y);
                    z_reg  <= '0;
                end
            end
        end
        if (state_reg == ST_CORD && step_reg != STEP_W'(RUN_STEPS))
        begin
            if (cy_reg > 0)
            begin
                cx_reg <= cx_reg + shy;
                cy_reg <= cy_reg - shx;
                z_reg  <= z_reg + atan_entry(step_reg);
            end
            else
            begin
                cx_reg <= cx_reg - shy;
                cy_reg <= cy_reg + shx;
                z_reg  <= z_reg - atan_entry(step_reg);
            end
            step_reg <= step_reg + 1'b1;
        end
        if (state_reg == ST_DONE && (!ov_reg || !out_stall))
        begin
            odx_reg <= drv_x;
            ody_reg <= drv_y;
            if (use_reg)
                oh_reg <= sh_reg;
            else if (drv_y == 0)
                oh_reg <= (drv_x >= 0) ? 9'sd0 : 9'sd180;
            else if (drv_x == 0)
                oh_reg <= (drv_y > 0) ? 9'sd90 : -9'sd90;
            else if (drv_x == drv_y)
                oh_reg <= (drv_x > 0) ? 9'sd45 : -9'sd135;
            else if (33'(drv_x) == -33'(drv_y))
                oh_reg <= (drv_x > 0) ? -9'sd45 : 9'sd135;
            else if ((z_reg >>> ANG_FRAC) > 180)
                oh_reg <= 9'sd180;
            else if ((z_reg >>> ANG_FRAC) < -180)
                oh_reg <= -9'sd180;
            else
                oh_reg <= 9'(z_reg >>> ANG_FRAC);
        end
    end

    assign out_valid   = ov_reg;
    assign heading_deg = oh_reg;
    assign drive_x     = odx_reg;
    assign drive_y     = ody_reg;

    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> in_stall)
        else $error("input taken while busy");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == ST_IDLE))
        else $error("config open while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("result dropped");
endmodule
